>>> rtl/hsv_to_rgb_converter_unit_defines.svh
// Assertion macros used by the checker file of this block.
// Both macros need clk in scope; HSVRGB_ASSERT_NXT also needs arst_n.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define HSVRGB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// Same check, but also active while reset is asserted.
`define HSVRGB_ASSERT_RST(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

	localparam int unsigned HUE_W            = 13;
	localparam int unsigned CHAN_W           = 8;
	localparam int unsigned REM_W            = 10;
	localparam int unsigned HUE_PER_SECTOR   = 960;
	localparam int unsigned SECTORS          = 6;
	localparam int unsigned HUE_LIMIT        = HUE_PER_SECTOR * SECTORS;
	localparam int unsigned CHANNEL_BITS_DEF = 8;
	localparam int unsigned QUEUE_DEPTH_DEF  = 4;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

	// One classified pixel as it waits between the front end and the datapath.
	typedef struct packed {
		logic              black;
		sector_t           sector;
		logic [REM_W-1:0]  rem;
		logic [CHAN_W-1:0] sat;
		logic [CHAN_W-1:0] val;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

	typedef struct packed {
		logic avail;
		job_t job;
	} head_t;

endpackage

>>> rtl/hsvrgb_if.sv
interface hsvrgb_in_if;
	import hsvrgb_pkg::*;

	logic              valid;
	logic              ready;
	logic [HUE_W-1:0]  hue;
	logic [CHAN_W-1:0] saturation;
	logic [CHAN_W-1:0] brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvrgb_out_if;
	import hsvrgb_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

>>> rtl/hsvrgb_front.sv
module hsvrgb_front (
	hsvrgb_in_if.sink          hsv,
	input  logic               full,
	output hsvrgb_pkg::push_t  wr
);
	import hsvrgb_pkg::*;

	logic [HUE_W-1:0] base;
	logic [HUE_W-1:0] offset;

	assign hsv.ready = !full;
	assign offset    = hsv.hue - base;

	// The sector is the last threshold the hue reaches; thresholds are independent compares.
	always_comb begin
		wr.push       = hsv.valid && hsv.ready;
		wr.job.sat    = hsv.saturation;
		wr.job.val    = hsv.brightness;
		wr.job.black  = 1'b0;
		wr.job.sector = SEC_0;
		base          = '0;
		if (hsv.hue >= HUE_W'(HUE_LIMIT)) begin
			wr.job.black = 1'b1;
		end else begin
			for (int k = 1; k < SECTORS; k++) begin
				if (hsv.hue >= HUE_W'(k * HUE_PER_SECTOR)) begin
					wr.job.sector = sector_t'(k);
					base          = HUE_W'(k * HUE_PER_SECTOR);
				end
			end
		end
		wr.job.rem = offset[REM_W-1:0];
	end

endmodule

>>> rtl/hsvrgb_queue.sv
module hsvrgb_queue #(
	parameter int unsigned DEPTH = hsvrgb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hsvrgb_pkg::push_t  wr,
	output logic               full,
	input  logic               pop,
	output hsvrgb_pkg::head_t  head
);
	import hsvrgb_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head.avail = (count_q != '0);
	assign head.job   = mem[rd_ptr_q];
	assign do_push    = wr.push && !full;
	assign do_pop     = pop && head.avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/hsvrgb_back.sv
module hsvrgb_back #(
	parameter int unsigned CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hsvrgb_pkg::head_t  head,
	output logic               pop,
	hsvrgb_out_if.source       rgb
);
	import hsvrgb_pkg::*;

	localparam int unsigned CB = CHANNEL_BITS;
	localparam int unsigned VW = (CB < CHAN_W) ? CB : CHAN_W;
	localparam int unsigned DW = CB + REM_W;
	localparam int unsigned NW = VW + DW;
	localparam int unsigned RW = VW + 1;
	localparam logic [CB-1:0] MAXC = {CB{1'b1}};
	localparam logic [DW-1:0] DEN  = DW'(HUE_PER_SECTOR * ((2 ** CB) - 1));
	localparam logic [NW-1:0] HALF = NW'(HUE_PER_SECTOR * ((2 ** CB) - 1) / 2);
	// Reciprocal of the denominator scaled by 2^NW. Every numerator is below 2^NW, so the
	// quotient it estimates is the true one or one less.
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << NW) / 64'(DEN));

	function automatic logic [VW-1:0] quo_est(input logic [NW-1:0] n);
		logic [NW+RW-1:0] prod;
		prod = (NW+RW)'(n) * (NW+RW)'(RECIP);
		return prod[NW +: VW];
	endfunction

	function automatic logic [VW-1:0] quo_fix(input logic [NW-1:0] n, input logic [VW-1:0] qe);
		logic [NW-1:0] r;
		r = n - NW'(qe) * NW'(DEN);
		return (r >= NW'(DEN)) ? qe + 1'b1 : qe;
	endfunction

	logic adv;

	// Stage 1: saturation products and the q/t numerator factors.
	logic                s_in;
	logic [VW-1:0]       sat_in;
	logic [VW+REM_W-1:0] srem;
	logic [VW+REM_W-1:0] scomp;
	logic [REM_W-1:0]    rcomp;

	logic                vld_s1;
	logic                blk_s1;
	sector_t             sec_s1;
	logic [VW-1:0]       val_s1;
	logic [CB-1:0]       ms_s1;
	logic [DW-1:0]       nq_s1;
	logic [DW-1:0]       nt_s1;

	// Stage 2: rounded numerators.
	logic [VW+CB-1:0]    pm;
	logic [NW-1:0]       pm_w;
	logic                vld_s2;
	logic                blk_s2;
	sector_t             sec_s2;
	logic [VW-1:0]       val_s2;
	logic [NW-1:0]       pnum_s2;
	logic [NW-1:0]       qnum_s2;
	logic [NW-1:0]       tnum_s2;

	// Stage 3: quotient estimates.
	logic                vld_s3;
	logic                blk_s3;
	sector_t             sec_s3;
	logic [VW-1:0]       val_s3;
	logic [NW-1:0]       pnum_s3;
	logic [NW-1:0]       qnum_s3;
	logic [NW-1:0]       tnum_s3;
	logic [VW-1:0]       pest_s3;
	logic [VW-1:0]       qest_s3;
	logic [VW-1:0]       test_s3;

	// Stage 4: corrected quotients.
	logic                vld_s4;
	logic                blk_s4;
	sector_t             sec_s4;
	logic [VW-1:0]       val_s4;
	logic [VW-1:0]       pquo_s4;
	logic [VW-1:0]       qquo_s4;
	logic [VW-1:0]       tquo_s4;

	logic                out_vld_q;
	logic [CHAN_W-1:0]   red_q;
	logic [CHAN_W-1:0]   green_q;
	logic [CHAN_W-1:0]   blue_q;
	logic [CHAN_W-1:0]   vv;
	logic [CHAN_W-1:0]   pv;
	logic [CHAN_W-1:0]   qv;
	logic [CHAN_W-1:0]   tv;
	logic [CHAN_W-1:0]   r_nx;
	logic [CHAN_W-1:0]   g_nx;
	logic [CHAN_W-1:0]   b_nx;

	// The whole datapath moves as one; a stalled result freezes every stage.
	assign adv = !out_vld_q || rgb.ready;
	assign pop = adv && head.avail;
	assign s_in = 1'b0;

	assign sat_in = head.job.sat[VW-1:0];
	assign rcomp  = REM_W'(HUE_PER_SECTOR) - head.job.rem;
	assign srem   = (VW+REM_W)'(sat_in) * (VW+REM_W)'(head.job.rem);
	assign scomp  = (VW+REM_W)'(sat_in) * (VW+REM_W)'(rcomp);

	always_ff @(posedge clk) begin
		if (adv) begin
			blk_s1 <= head.job.black;
			sec_s1 <= head.job.sector;
			val_s1 <= head.job.val[VW-1:0];
			ms_s1  <= MAXC - CB'(sat_in);
			nq_s1  <= DEN - DW'(srem);
			nt_s1  <= DEN - DW'(scomp);
		end
	end

	// Stage 2: numerators over the common denominator 960*M, with the rounding half added.
	assign pm   = (VW+CB)'(val_s1) * (VW+CB)'(ms_s1);
	assign pm_w = NW'(pm);

	always_ff @(posedge clk) begin
		if (adv) begin
			blk_s2  <= blk_s1;
			sec_s2  <= sec_s1;
			val_s2  <= val_s1;
			pnum_s2 <= (pm_w << 10) - (pm_w << 6) + HALF;
			qnum_s2 <= NW'(val_s1) * NW'(nq_s1) + HALF;
			tnum_s2 <= NW'(val_s1) * NW'(nt_s1) + HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			blk_s3  <= blk_s2;
			sec_s3  <= sec_s2;
			val_s3  <= val_s2;
			pnum_s3 <= pnum_s2;
			qnum_s3 <= qnum_s2;
			tnum_s3 <= tnum_s2;
			pest_s3 <= quo_est(pnum_s2);
			qest_s3 <= quo_est(qnum_s2);
			test_s3 <= quo_est(tnum_s2);
		end
	end

	// The remainder left by the estimate tells whether one more denominator fits.
	always_ff @(posedge clk) begin
		if (adv) begin
			blk_s4  <= blk_s3;
			sec_s4  <= sec_s3;
			val_s4  <= val_s3;
			pquo_s4 <= quo_fix(pnum_s3, pest_s3);
			qquo_s4 <= quo_fix(qnum_s3, qest_s3);
			tquo_s4 <= quo_fix(tnum_s3, test_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= pop;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_vld_q <= vld_s4;
		end
	end

	assign vv = CHAN_W'(val_s4);
	assign pv = CHAN_W'(pquo_s4);
	assign qv = CHAN_W'(qquo_s4);
	assign tv = CHAN_W'(tquo_s4);

	always_comb begin
		r_nx = '0;
		g_nx = '0;
		b_nx = '0;
		if (!blk_s4) begin
			case (sec_s4)
				SEC_0: begin
					r_nx = vv; g_nx = tv; b_nx = pv;
				end
				SEC_1: begin
					r_nx = qv; g_nx = vv; b_nx = pv;
				end
				SEC_2: begin
					r_nx = pv; g_nx = vv; b_nx = tv;
				end
				SEC_3: begin
					r_nx = pv; g_nx = qv; b_nx = vv;
				end
				SEC_4: begin
					r_nx = tv; g_nx = pv; b_nx = vv;
				end
				SEC_5: begin
					r_nx = vv; g_nx = pv; b_nx = qv;
				end
				default: begin
					r_nx = '0; g_nx = '0; b_nx = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_q   <= r_nx;
			green_q <= g_nx;
			blue_q  <= b_nx;
		end
	end

	assign rgb.valid = out_vld_q;
	assign rgb.red   = red_q | CHAN_W'(s_in);
	assign rgb.green = green_q;
	assign rgb.blue  = blue_q;

endmodule

>>> rtl/hsv_to_rgb_converter_unit.sv
// Port    Role    Handshake      Item contents
// hsv     sink    valid/ready    hue (1/16 degree), saturation, brightness
// rgb     source  valid/ready    red, green, blue
//
// Sustained rate is one item per clock cycle while rgb.ready is high.
// From accept, an item passes through the queue, four datapath stages (products,
// numerators, reciprocal estimate of the division by 960*M, remainder correction) and the
// output register.
// Reset clears the queue pointers, the count and the stage valid bits, but no data.
// A stalled result freezes the datapath; the queue then takes up to QUEUE_DEPTH items
// before hsv.ready drops.
module hsv_to_rgb_converter_unit #(
	parameter int unsigned CHANNEL_BITS = hsvrgb_pkg::CHANNEL_BITS_DEF,
	parameter int unsigned QUEUE_DEPTH  = hsvrgb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	hsvrgb_in_if.sink     hsv,
	hsvrgb_out_if.source  rgb
);
	import hsvrgb_pkg::*;

	push_t wr;
	head_t head;
	logic  full;
	logic  pop;

	hsvrgb_front u_front (
		.hsv  (hsv),
		.full (full),
		.wr   (wr)
	);

	hsvrgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.full   (full),
		.pop    (pop),
		.head   (head)
	);

	hsvrgb_back #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.rgb    (rgb)
	);

endmodule

>>> rtl/hsvrgb_checker.sv
`include "hsv_to_rgb_converter_unit_defines.svh"

module hsvrgb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hsvrgb_pkg::CHAN_W-1:0] red,
	input logic [hsvrgb_pkg::CHAN_W-1:0] green,
	input logic [hsvrgb_pkg::CHAN_W-1:0] blue
);

	// A waiting result must not change or vanish.
	`HSVRGB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue), "result changed while stalled")

	// Without a new item the queue cannot fill, so ready must not drop.
	`HSVRGB_ASSERT_NXT(a_ready_keeps, in_ready && !in_valid, in_ready, "ready dropped with no item accepted")

	// Reset empties the datapath.
	`HSVRGB_ASSERT_RST(a_reset_empty, !arst_n, !out_valid, "result valid right after reset")

endmodule

bind hsv_to_rgb_converter_unit hsvrgb_checker u_hsvrgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (hsv.valid),
	.in_ready  (hsv.ready),
	.out_valid (rgb.valid),
	.out_ready (rgb.ready),
	.red       (rgb.red),
	.green     (rgb.green),
	.blue      (rgb.blue)
);
